// File: hw/rtl/fte_pkg.sv
`timescale 1ns / 1ps

package fte_pkg;

   localparam int CHAR_W      = 7;
   localparam int TEXT_MAX    = 12;
   localparam int COUNT_W     = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam int FLOAT_W = 32;
   localparam int EFIELD_W = 8;
   localparam int FRAC_W  = 23;
   localparam int SIG_W   = 24;
   localparam int PROD_W  = 48;
   localparam int VALUE_W = 32;
   localparam int DIGITS_W = 3;
   localparam int SHIFT_W = 6;

   localparam int EXP_BIAS = 127;
   localparam logic [EFIELD_W-1:0] EFIELD_SPECIAL = 8'hFF;
   localparam logic [EFIELD_W-1:0] EFIELD_OVF     = 8'(EXP_BIAS + 31);
   localparam logic [EFIELD_W-1:0] EFIELD_POINT   = 8'(EXP_BIAS + 23);

   // Reciprocal of ten: floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for 32-bit v.
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_UP_N  = 7'h4E;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
   localparam logic [CHAR_W-1:0] CH_UP_I  = 7'h49;
   localparam logic [CHAR_W-1:0] CH_LO_N  = 7'h6E;
   localparam logic [CHAR_W-1:0] CH_LO_F  = 7'h66;
   localparam logic [CHAR_W-1:0] CH_UP_O  = 7'h4F;
   localparam logic [CHAR_W-1:0] CH_LO_V  = 7'h76;

   // Text as queued: character 0 is the first one sent.
   typedef struct packed {
      logic [TEXT_MAX-1:0][CHAR_W-1:0] chars;
      logic [COUNT_W-1:0]              count;
   } text_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_MUL,
      FS_SHIFT,
      FS_DIGIT,
      FS_PUSH
   } front_state_type;

   function automatic logic [SIG_W-1:0] pow_ten(input logic [DIGITS_W-1:0] p);
      logic [SIG_W-1:0] r;
      unique case (p)
         3'd0: r = 24'd1;
         3'd1: r = 24'd10;
         3'd2: r = 24'd100;
         3'd3: r = 24'd1000;
         3'd4: r = 24'd10000;
         3'd5: r = 24'd100000;
         3'd6: r = 24'd1000000;
         3'd7: r = 24'd10000000;
         default: r = 24'd1;
      endcase
      return r;
   endfunction

   // Large exponents leave fewer fraction digits so the scaled value stays in 32 bits.
   function automatic logic [DIGITS_W-1:0] cap_digits(input logic [EFIELD_W-1:0] efield,
                                                      input logic [DIGITS_W-1:0] req);
      logic [DIGITS_W-1:0] lim;
      priority if (efield > 8'(EXP_BIAS + 27)) lim = 3'd0;
      else if (efield > 8'(EXP_BIAS + 24))     lim = 3'd1;
      else if (efield > 8'(EXP_BIAS + 21))     lim = 3'd2;
      else if (efield > 8'(EXP_BIAS + 17))     lim = 3'd3;
      else if (efield > 8'(EXP_BIAS + 14))     lim = 3'd4;
      else if (efield > 8'(EXP_BIAS + 11))     lim = 3'd5;
      else if (efield > 8'(EXP_BIAS + 7))      lim = 3'd6;
      else                                     lim = 3'd7;
      return (req < lim) ? req : lim;
   endfunction

   function automatic text_entry_type prepend(input text_entry_type t,
                                              input logic [CHAR_W-1:0] c);
      text_entry_type r;
      r.chars = {t.chars[TEXT_MAX-2:0], c};
      r.count = t.count + COUNT_W'(1);
      return r;
   endfunction

   function automatic text_entry_type three_chars(input logic [CHAR_W-1:0] c0,
                                                  input logic [CHAR_W-1:0] c1,
                                                  input logic [CHAR_W-1:0] c2);
      text_entry_type r;
      r.chars    = '0;
      r.chars[0] = c0;
      r.chars[1] = c1;
      r.chars[2] = c2;
      r.count    = COUNT_W'(3);
      return r;
   endfunction

endpackage

// File: hw/rtl/float_to_decimal_text_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                   Accepted when
// req       in         req_float_bits                          req_valid && !req_stall
// rsp       out        rsp_text_char, rsp_last_char            rsp_valid && !rsp_stall
// csr       in         csr_write_data                          csr_write_enable
//
// The front end takes a number through its multiply, shift, digit loop and push states, and takes
// NaN, Inf and overflow straight from idle to push; the digit loop divides by ten for each digit.
// The back end sends one character per cycle while rsp is not stalled, up to 12 per number,
// from a two-entry queue.
// Reset is synchronous and active high; it clears the queue, both controllers and the csr.
// A stalled rsp holds its character; the front end keeps working until the queue is full.

module float_to_decimal_text_unit #(
   parameter int QUEUE_DEPTH = fte_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fte_pkg::DIGITS_W-1:0]  csr_write_data,
   input  logic                          req_valid,
   input  logic [fte_pkg::FLOAT_W-1:0]   req_float_bits,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fte_pkg::CHAR_W-1:0]    rsp_text_char,
   output logic                          rsp_last_char
);
   import fte_pkg::*;

   queue_status_type q_status;
   text_entry_type   push_entry;
   text_entry_type   pop_entry;
   logic             q_push;
   logic             q_pop;

   fte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_float_bits   (req_float_bits),
      .req_stall        (req_stall),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   fte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   fte_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_entry       (pop_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

   // The front end takes no new item in the cycle after it took one.
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("front end accepted two items back to back");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   // With nothing queued, the item after the final character of a text is a bubble.
   a_text_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_char && q_status.empty) |=> !rsp_valid)
      else $error("character sent after end of text with empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

// File: hw/rtl/fte_front.sv
`timescale 1ns / 1ps

module fte_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [fte_pkg::DIGITS_W-1:0]   csr_write_data,
   input  logic                           req_valid,
   input  logic [fte_pkg::FLOAT_W-1:0]    req_float_bits,
   output logic                           req_stall,
   input  fte_pkg::queue_status_type      q_status,
   output logic                           q_push,
   output fte_pkg::text_entry_type        q_entry
);
   import fte_pkg::*;

   front_state_type state_ff, state_in;

   logic [DIGITS_W-1:0] digits_ff;
   logic [SIG_W-1:0]    sig_ff;
   logic [DIGITS_W-1:0] p_ff;
   logic                left_ff;
   logic [SHIFT_W-1:0]  amt_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [VALUE_W-1:0]  v_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                neg_ff;
   logic                sign_ok_ff;
   text_entry_type      text_ff;

   logic [EFIELD_W-1:0] efield;
   logic [FRAC_W-1:0]   frac;
   logic                is_special;
   logic                accept;

   logic [2*VALUE_W-1:0] q_wide;
   logic [VALUE_W-1:0]   quot;
   logic [3:0]           rem;
   logic [3:0]           q_times_ten;
   logic                 point_now;
   logic [VALUE_W-1:0]   v_next;
   logic [COUNT_W-1:0]   cnt_next;
   logic                 more_digits;
   logic [CHAR_W-1:0]    digit_char;
   logic [EFIELD_W-1:0]  right_diff;

   assign efield     = req_float_bits[FLOAT_W-2 -: EFIELD_W];
   assign frac       = req_float_bits[FRAC_W-1:0];
   assign is_special = (efield == EFIELD_SPECIAL) || (efield > EFIELD_OVF);
   assign accept     = req_valid && !req_stall;
   assign right_diff = EFIELD_POINT - efield;

   // One decimal digit per cycle, or the point in its place; only the low four bits are needed for the remainder.
   always_comb begin
      q_wide      = {{VALUE_W{1'b0}}, v_ff} * {{VALUE_W{1'b0}}, RECIP_TEN};
      quot        = VALUE_W'(q_wide[2*VALUE_W-1:RECIP_SHIFT]);
      q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
      rem         = v_ff[3:0] - q_times_ten;
      point_now   = (p_ff != '0) && (cnt_ff == COUNT_W'(p_ff));
      v_next      = point_now ? v_ff : quot;
      cnt_next    = cnt_ff + COUNT_W'(1);
      digit_char  = point_now ? CH_POINT : (CH_ZERO + CHAR_W'(rem));
      more_digits = (v_next != '0) ||
                    ((p_ff != '0) && (cnt_next <= (COUNT_W'(p_ff) + COUNT_W'(1))));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE:  if (req_valid) state_in = is_special ? FS_PUSH : FS_MUL;
         FS_MUL:   state_in = FS_SHIFT;
         FS_SHIFT: state_in = FS_DIGIT;
         FS_DIGIT: if (!more_digits) state_in = FS_PUSH;
         FS_PUSH:  if (!q_status.full) state_in = FS_IDLE;
         default:  state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != FS_IDLE);
      q_push    = (state_ff == FS_PUSH) && !q_status.full;
      q_entry   = (sign_ok_ff && neg_ff) ? prepend(text_ff, CH_MINUS) : text_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FS_IDLE;
         digits_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) digits_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               neg_ff     <= req_float_bits[FLOAT_W-1];
               cnt_ff     <= '0;
               sig_ff     <= (efield != '0) ? {1'b1, frac} : {frac, 1'b0};
               p_ff       <= cap_digits(efield, digits_ff);
               left_ff    <= (efield > EFIELD_POINT);
               if (efield > EFIELD_POINT) begin
                  amt_ff <= SHIFT_W'(efield - EFIELD_POINT);
               end else begin
                  amt_ff <= (right_diff > EFIELD_W'({SHIFT_W{1'b1}})) ?
                            {SHIFT_W{1'b1}} : right_diff[SHIFT_W-1:0];
               end
               if (efield == EFIELD_SPECIAL) begin
                  if (frac != '0) begin
                     text_ff    <= three_chars(CH_UP_N, CH_LO_A, CH_UP_N);
                     sign_ok_ff <= 1'b0;
                  end else begin
                     text_ff    <= three_chars(CH_UP_I, CH_LO_N, CH_LO_F);
                     sign_ok_ff <= 1'b1;
                  end
               end else if (efield > EFIELD_OVF) begin
                  text_ff    <= three_chars(CH_UP_O, CH_LO_V, CH_LO_F);
                  sign_ok_ff <= 1'b1;
               end else begin
                  text_ff    <= '0;
                  sign_ok_ff <= 1'b1;
               end
            end
         end
         FS_MUL: begin
            prod_ff <= {{(PROD_W-SIG_W){1'b0}}, sig_ff} *
                       {{(PROD_W-SIG_W){1'b0}}, pow_ten(p_ff)};
         end
         FS_SHIFT: begin
            v_ff <= left_ff ? VALUE_W'(prod_ff << amt_ff) : VALUE_W'(prod_ff >> amt_ff);
         end
         FS_DIGIT: begin
            v_ff    <= v_next;
            cnt_ff  <= cnt_next;
            text_ff <= prepend(text_ff, digit_char);
         end
         FS_PUSH: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/fte_queue.sv
`timescale 1ns / 1ps

module fte_queue #(
   parameter int DEPTH = fte_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fte_pkg::text_entry_type   push_entry,
   input  logic                      pop,
   output fte_pkg::text_entry_type   pop_entry,
   output fte_pkg::queue_status_type status
);
   import fte_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   text_entry_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   fill_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign pop_entry    = mem_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.empty = (fill_ff == '0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)      fill_ff <= fill_ff + CNT_W'(1);
         else if (pop && !push) fill_ff <= fill_ff - CNT_W'(1);
      end
   end

endmodule

// File: hw/rtl/fte_emit.sv
`timescale 1ns / 1ps

module fte_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  fte_pkg::queue_status_type      q_status,
   input  fte_pkg::text_entry_type        q_entry,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fte_pkg::CHAR_W-1:0]     rsp_text_char,
   output logic                           rsp_last_char
);
   import fte_pkg::*;

   logic [TEXT_MAX-1:0][CHAR_W-1:0] chars_ff;
   logic [COUNT_W-1:0]              left_ff;
   logic                            active_ff;
   logic                            take;
   logic                            is_last;

   assign is_last       = (left_ff == COUNT_W'(1));
   assign take          = active_ff && !rsp_stall;
   // The next text loads in the same cycle its predecessor's final item leaves.
   assign q_pop         = !q_status.empty && (!active_ff || (take && is_last));
   assign rsp_valid     = active_ff;
   assign rsp_text_char = chars_ff[0];
   assign rsp_last_char = is_last;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         chars_ff <= q_entry.chars;
         left_ff  <= q_entry.count;
      end else if (take) begin
         chars_ff <= {{CHAR_W{1'b0}}, chars_ff[TEXT_MAX-1:1]};
         left_ff  <= left_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (q_pop) begin
         active_ff <= 1'b1;
      end else if (take && is_last) begin
         active_ff <= 1'b0;
      end
   end

endmodule
